@@ rtl/wrs_pkg.sv @@
// shared types, constants and codes for the weighted random selector
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

    // field widths of the stream items
    localparam int unsigned IDX_FIELD_W = 4;
    localparam int unsigned WEIGHT_W    = 10;
    localparam int unsigned WTOT_W      = 14;
    localparam int unsigned SEL_W       = 8;

    // number of entries that an entry index can reach
    localparam int unsigned TABLE_SLOTS = 2 ** IDX_FIELD_W;

    // default table depth
    localparam int unsigned MAX_ENTRIES_DEF = 16;

    // item kinds, carried on tuser
    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_SELECT = 1'b1
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_WR_MOD = 2'd1,
        ST_WALK   = 2'd2,
        ST_DONE   = 2'd3
    } state_t;

    // one input item
    typedef struct packed {
        op_t                    opcode;
        logic [IDX_FIELD_W-1:0] entry_index;
        logic [WEIGHT_W-1:0]    weight_value;
        logic [WTOT_W-1:0]      random_draw;
    } item_t;

    // one result item
    typedef struct packed {
        logic [SEL_W-1:0]  selected_index;
        logic              used_fallback;
        logic [WTOT_W-1:0] weight_total;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/wrs_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module wrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/wrs_core.sv @@
// sequencer: weight update by read-modify-write and the cumulative table walk
`timescale 1ns / 1ps
`default_nettype none

module wrs_core #(
    parameter int unsigned MAX_ENTRIES = wrs_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire wrs_pkg::item_t                 item,
    input  wire logic [wrs_pkg::SEL_W-1:0]      fallback_index,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output wrs_pkg::result_t                    res,
    output logic                                ram_we,
    output logic [$clog2(MAX_ENTRIES)-1:0]      ram_waddr,
    output logic [wrs_pkg::WEIGHT_W-1:0]        ram_wdata,
    output logic [$clog2(MAX_ENTRIES)-1:0]      ram_raddr,
    input  wire logic [wrs_pkg::WEIGHT_W-1:0]   ram_rdata
);

    import wrs_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
    // entries beyond the reach of an entry index always hold zero
    localparam int unsigned WALK_N = (MAX_ENTRIES < TABLE_SLOTS) ? MAX_ENTRIES : TABLE_SLOTS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WALK_N - 1);

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [WTOT_W-1:0]      acc_reg, acc_next;
    logic [WTOT_W-1:0]      total_reg, total_next;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;

    logic                   accept;
    logic                   in_range;
    logic [IDX_W-1:0]       item_addr;
    logic [IDX_W-1:0]       op_addr;
    logic [WEIGHT_W-1:0]    w_cur;
    logic [WEIGHT_W-1:0]    w_old;
    logic [WTOT_W-1:0]      acc_sum;
    logic                   cand;

    // decode and walk arithmetic
    always_comb
    begin
        accept    = item_valid && item_ready;
        in_range  = 32'(item.entry_index) < MAX_ENTRIES;
        item_addr = IDX_W'(item.entry_index);
        op_addr   = IDX_W'(item_reg.entry_index);
        // an entry never written reads as zero
        w_cur     = valid_reg[rd_idx_reg] ? ram_rdata : '0;
        w_old     = valid_reg[op_addr] ? ram_rdata : '0;
        acc_sum   = acc_reg + WTOT_W'(w_cur);
        cand      = (item_reg.random_draw < acc_sum) && (w_cur != '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.opcode == OP_SELECT)
                    begin
                        state_next = ST_WALK;
                    end
                    else if (in_range)
                    begin
                        state_next = ST_WR_MOD;
                    end
                end
            end
            ST_WR_MOD:
            begin
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (cand || (rd_idx_reg == LAST_IDX))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        item_next    = item_reg;
        rd_idx_next  = rd_idx_reg;
        acc_next     = acc_reg;
        total_next   = total_reg;
        valid_next   = valid_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next   = item;
                    rd_idx_next = '0;
                    acc_next    = '0;
                end
            end
            ST_WR_MOD:
            begin
                total_next = total_reg - WTOT_W'(w_old) + WTOT_W'(item_reg.weight_value);
                valid_next[op_addr] = 1'b1;
            end
            ST_WALK:
            begin
                acc_next     = acc_sum;
                rd_idx_next  = IDX_W'(rd_idx_reg + 1'b1);
                hit_next     = cand;
                hit_idx_next = rd_idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        item_ready = 1'b0;
        res_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                // a select starts reading at entry zero
                ram_raddr  = (item.opcode == OP_SELECT) ? '0 : item_addr;
            end
            ST_WR_MOD:
            begin
                ram_we = 1'b1;
            end
            ST_WALK:
            begin
                ram_raddr = IDX_W'(rd_idx_reg + 1'b1);
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
        ram_waddr          = op_addr;
        ram_wdata          = item_reg.weight_value;
        res.selected_index = hit_reg ? SEL_W'(hit_idx_reg) : fallback_index;
        res.used_fallback  = !hit_reg;
        res.weight_total   = total_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        rd_idx_reg  <= rd_idx_next;
        acc_reg     <= acc_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
    end

endmodule

`default_nettype wire

@@ rtl/weighted_random_selector_top.sv @@
// top level of the weighted random selector: stream ports, config register, result register
// a weight write reads the stored weight on transfer and writes the new one in ST_WR_MOD before the next input transfer
// a select walks one stored weight per cycle up to the first matching entry or the last reachable
// one, and the next input is taken once the result is out
// the single ram read port sets the walk rate; the result register lets writes go on meanwhile
// reset (rst_n low, asynchronous) makes all weights read as zero and clears the total and the fallback index
`timescale 1ns / 1ps
`default_nettype none

module weighted_random_selector_top #(
    parameter int unsigned MAX_ENTRIES = wrs_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [31:0]                 s_axis_tdata,  // entry_index, weight_value, random_draw
    input  wire logic [0:0]                  s_axis_tuser,  // opcode
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // selected_index, weight_total
    output logic [0:0]                       m_axis_tuser,  // used_fallback
    input  wire logic                        cfg_we,
    input  wire logic [wrs_pkg::SEL_W-1:0]   cfg_wdata
);

    import wrs_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);

    item_t               item;
    result_t             res;
    logic                res_valid;
    logic                res_ready;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WEIGHT_W-1:0] ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WEIGHT_W-1:0] ram_rdata;

    logic [SEL_W-1:0]    fallback_reg;
    logic                m_valid_reg;
    result_t             m_data_reg;

    // unpack the input transfer
    always_comb
    begin
        item.opcode       = op_t'(s_axis_tuser[0]);
        item.entry_index  = s_axis_tdata[3:0];
        item.weight_value = s_axis_tdata[13:4];
        item.random_draw  = s_axis_tdata[27:14];
    end

    // fallback index register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg <= '0;
        end
        else if (cfg_we)
        begin
            fallback_reg <= cfg_wdata;
        end
    end

    wrs_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (s_axis_tvalid),
        .item_ready     (s_axis_tready),
        .item           (item),
        .fallback_index (fallback_reg),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    wrs_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result register, free when empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_data_reg <= res;
        end
    end

    // pack the output transfer
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_data_reg.weight_total, m_data_reg.selected_index};
    assign m_axis_tuser  = m_data_reg.used_fallback;

endmodule

`default_nettype wire

@@ rtl/wrs_checker.sv @@
// port-level checks for the weighted random selector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module wrs_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [0:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,
    input  wire logic [0:0]  m_axis_tuser
);

    import wrs_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

    // a matched entry always lies within the reachable table
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:4] == 4'd0)
    else $error("matched index outside the table");

    // a weight write never raises a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_WRITE) && !m_axis_tvalid
            |=> !m_axis_tvalid)
    else $error("result after a weight write");

    // a select keeps the input side closed while it walks
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_SELECT) |=> !s_axis_tready)
    else $error("input taken during a walk");

endmodule

bind weighted_random_selector_top wrs_checker u_wrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
